@@ hdl/byte_stream_tokenizer_assert.svh @@
// Assertion macros shared by the tokenizer modules.
`ifndef BYTE_STREAM_TOKENIZER_ASSERT_SVH
`define BYTE_STREAM_TOKENIZER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define BST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define BST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

@@ hdl/bst_pkg.sv @@
`default_nettype none
package bst_pkg;

    typedef enum logic [4:0] {
        K_ILLEGAL = 5'd0,
        K_END     = 5'd1,
        K_IDENT   = 5'd2,
        K_INT     = 5'd3,
        K_ASSIGN  = 5'd4,
        K_EQ      = 5'd5,
        K_PLUS    = 5'd6,
        K_MINUS   = 5'd7,
        K_BANG    = 5'd8,
        K_NOTEQ   = 5'd9,
        K_SLASH   = 5'd10,
        K_STAR    = 5'd11,
        K_LT      = 5'd12,
        K_GT      = 5'd13,
        K_COMMA   = 5'd14,
        K_SEMI    = 5'd15,
        K_LPAREN  = 5'd16,
        K_RPAREN  = 5'd17,
        K_LBRACE  = 5'd18,
        K_RBRACE  = 5'd19
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
    } t_token;

    // One queue entry holds every token caused by one source byte.
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_qentry;

    typedef struct packed {
        logic    valid;
        t_qentry entry;
    } t_qhead;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

endpackage
`default_nettype wire

@@ hdl/byte_stream_tokenizer.sv @@
// Byte stream tokenizer.
// Source channel: i_src_valid / o_src_stall carry one byte per request on
// i_source_byte; a zero byte ends the input. Token channel: o_tok_valid /
// i_tok_stall carry one token per request (kind, start offset, length, and
// o_last_of_item on the final token caused by a source byte).
// A source byte is taken every cycle while the four-entry token queue has
// room. A byte that both closes a pending token and starts a token of its
// own yields two tokens, which leave one per cycle; with i_tok_stall low the
// output side runs at one token per cycle, so bytes with at most one token
// stream at one a cycle. Identifier, integer, '=' and '!' tokens leave only
// once the next byte closes them; any other token goes through the token
// queue into the output register after its byte is taken.
// When i_tok_stall is high the output register holds its token, the queue
// fills, and o_src_stall rises once the queue is full.
// Reset clears the pending token, the offset counter, the queue and the
// output valid flag; no tokens are lost or invented across a stall.
`default_nettype none
module byte_stream_tokenizer #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_src_valid,
    output logic             o_src_stall,
    input  wire logic [7:0]  i_source_byte,
    output logic             o_tok_valid,
    input  wire logic        i_tok_stall,
    output logic [4:0]       o_token_kind,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic             o_last_of_item
);

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    bst_pkg::t_qentry w_entry;
    bst_pkg::t_qhead  w_head;

    bst_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_src_valid   (i_src_valid),
        .i_source_byte (i_source_byte),
        .i_q_full      (w_full),
        .o_src_stall   (o_src_stall),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    bst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    bst_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_tok_valid    (o_tok_valid),
        .i_tok_stall    (i_tok_stall),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_item (o_last_of_item)
    );

endmodule
`default_nettype wire

@@ hdl/bst_front.sv @@
`default_nettype none
module bst_front #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_src_valid,
    input  wire logic [7:0]      i_source_byte,
    input  wire logic            i_q_full,
    output logic                 o_src_stall,
    output logic                 o_push,
    output bst_pkg::t_qentry     o_entry
);

    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_UNDER = 8'h5F;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        PC_NONE,
        PC_IDENT,
        PC_INT,
        PC_ASSIGN,
        PC_BANG
    } t_pend;

    function automatic bst_pkg::t_kind single_kind(input logic [7:0] c);
        case (c)
            8'h2B:   single_kind = bst_pkg::K_PLUS;
            8'h2D:   single_kind = bst_pkg::K_MINUS;
            8'h2F:   single_kind = bst_pkg::K_SLASH;
            8'h2A:   single_kind = bst_pkg::K_STAR;
            8'h3C:   single_kind = bst_pkg::K_LT;
            8'h3E:   single_kind = bst_pkg::K_GT;
            8'h2C:   single_kind = bst_pkg::K_COMMA;
            8'h3B:   single_kind = bst_pkg::K_SEMI;
            8'h28:   single_kind = bst_pkg::K_LPAREN;
            8'h29:   single_kind = bst_pkg::K_RPAREN;
            8'h7B:   single_kind = bst_pkg::K_LBRACE;
            8'h7D:   single_kind = bst_pkg::K_RBRACE;
            default: single_kind = bst_pkg::K_ILLEGAL;
        endcase
    endfunction

    t_pend                  r_pc, n_pc;
    logic [15:0]            r_pstart, n_pstart;
    logic [15:0]            r_plen, n_plen;
    logic [OFFSET_BITS-1:0] r_off, n_off;

    logic                   w_accept;
    logic                   w_letter, w_digit, w_space, w_nul;
    logic                   w_run;
    logic [OFFSET_BITS+15:0] w_off_ext;
    logic [15:0]            w_here;
    logic                   w_has_f, w_has_own, w_closed;
    bst_pkg::t_token        w_tokf, w_tokown;

    assign w_accept  = i_src_valid && !i_q_full;
    assign o_src_stall = i_q_full;

    assign w_letter = (i_source_byte >= 8'h61 && i_source_byte <= 8'h7A) ||
                      (i_source_byte >= 8'h41 && i_source_byte <= 8'h5A) ||
                      (i_source_byte == C_UNDER);
    assign w_digit  = (i_source_byte >= 8'h30 && i_source_byte <= 8'h39);
    assign w_space  = (i_source_byte == C_SPACE) || (i_source_byte == C_TAB) ||
                      (i_source_byte == C_CR) || (i_source_byte == C_LF);
    assign w_nul    = (i_source_byte == C_NUL);

    assign w_off_ext = {16'b0, r_off};
    assign w_here    = w_off_ext[15:0];

    // Extend a pending run without emitting anything.
    assign w_run = ((r_pc == PC_IDENT) && w_letter) || ((r_pc == PC_INT) && w_digit);

    always_comb begin
        n_pc      = r_pc;
        n_pstart  = r_pstart;
        n_plen    = r_plen;
        n_off     = r_off + 1'b1;
        w_has_f   = 1'b0;
        w_has_own = 1'b0;
        w_closed  = 1'b0;
        w_tokf.kind     = bst_pkg::K_ILLEGAL;
        w_tokf.start    = r_pstart;
        w_tokf.length   = r_plen;
        w_tokown.kind   = bst_pkg::K_ILLEGAL;
        w_tokown.start  = w_here;
        w_tokown.length = 16'd1;

        case (r_pc)
            PC_IDENT, PC_INT: begin
                if (!w_run) begin
                    w_has_f     = 1'b1;
                    w_tokf.kind = (r_pc == PC_IDENT) ? bst_pkg::K_IDENT : bst_pkg::K_INT;
                end
            end
            PC_ASSIGN, PC_BANG: begin
                w_has_f = 1'b1;
                if (i_source_byte == C_EQ) begin
                    w_closed      = 1'b1;
                    w_tokf.kind   = (r_pc == PC_ASSIGN) ? bst_pkg::K_EQ : bst_pkg::K_NOTEQ;
                    w_tokf.length = 16'd2;
                    n_pc          = PC_NONE;
                end else begin
                    w_tokf.kind   = (r_pc == PC_ASSIGN) ? bst_pkg::K_ASSIGN : bst_pkg::K_BANG;
                    w_tokf.length = 16'd1;
                end
            end
            default: ;
        endcase

        if (w_run) begin
            n_plen = (r_plen == LEN_MAX) ? r_plen : r_plen + 16'd1;
        end else if (!w_closed) begin
            n_pc = PC_NONE;
            if (w_nul) begin
                w_has_own       = 1'b1;
                w_tokown.kind   = bst_pkg::K_END;
                w_tokown.length = 16'd0;
                n_pstart        = 16'd0;
                n_plen          = 16'd0;
                n_off           = '0;
            end else if (w_space) begin
                // skip whitespace
            end else if (w_letter || w_digit || (i_source_byte == C_EQ) ||
                         (i_source_byte == C_BANG)) begin
                n_pc     = w_letter ? PC_IDENT :
                           w_digit  ? PC_INT   :
                           (i_source_byte == C_EQ) ? PC_ASSIGN : PC_BANG;
                n_pstart = w_here;
                n_plen   = 16'd1;
            end else begin
                w_has_own     = 1'b1;
                w_tokown.kind = single_kind(i_source_byte);
            end
        end
    end

    assign o_push       = w_accept && (w_has_f || w_has_own);
    assign o_entry.two  = w_has_f && w_has_own;
    assign o_entry.tok0 = w_has_f ? w_tokf : w_tokown;
    assign o_entry.tok1 = w_tokown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= PC_NONE;
            r_pstart <= 16'd0;
            r_plen   <= 16'd0;
            r_off    <= '0;
        end else if (w_accept) begin
            r_pc     <= n_pc;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_off    <= n_off;
        end
    end

endmodule
`default_nettype wire

@@ hdl/bst_queue.sv @@
`default_nettype none
`include "byte_stream_tokenizer_assert.svh"
module bst_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire bst_pkg::t_qentry  i_entry,
    input  wire logic              i_pop,
    output logic                   o_full,
    output bst_pkg::t_qhead        o_head
);

    bst_pkg::t_qentry            r_fifo [bst_pkg::QDEPTH];
    logic [bst_pkg::QPTR_W-1:0]  r_wr, n_wr;
    logic [bst_pkg::QPTR_W-1:0]  r_rd, n_rd;
    logic [bst_pkg::QCNT_W-1:0]  r_count, n_count;
    logic                        w_pop;

    assign o_full       = (r_count == bst_pkg::QCNT_W'(bst_pkg::QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_fifo[r_rd];
    assign w_pop        = i_pop && o_head.valid;

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = w_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_fifo[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `BST_ASSERT(a_count_bound, i_clk, i_rst_n, (r_count <= bst_pkg::QCNT_W'(bst_pkg::QDEPTH)), "queue count above depth")
    `BST_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, o_full, !i_push)

endmodule
`default_nettype wire

@@ hdl/bst_back.sv @@
`default_nettype none
`include "byte_stream_tokenizer_assert.svh"
module bst_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bst_pkg::t_qhead i_head,
    output logic                 o_pop,
    output logic                 o_tok_valid,
    input  wire logic            i_tok_stall,
    output logic [4:0]           o_token_kind,
    output logic [15:0]          o_token_start,
    output logic [15:0]          o_token_length,
    output logic                 o_last_of_item
);

    logic            r_valid, n_valid;
    logic            r_sel, n_sel;
    logic            r_last, n_last;
    bst_pkg::t_token r_tok, n_tok;
    logic            w_load;

    // Refill the output register when empty or being taken.
    assign w_load = !r_valid || !i_tok_stall;

    always_comb begin
        o_pop   = 1'b0;
        n_valid = r_valid;
        n_sel   = r_sel;
        n_last  = r_last;
        n_tok   = r_tok;
        if (w_load) begin
            if (i_head.valid) begin
                n_valid = 1'b1;
                if (!r_sel) begin
                    n_tok = i_head.entry.tok0;
                    if (i_head.entry.two) begin
                        n_sel  = 1'b1;
                        n_last = 1'b0;
                    end else begin
                        n_last = 1'b1;
                        o_pop  = 1'b1;
                    end
                end else begin
                    n_tok  = i_head.entry.tok1;
                    n_sel  = 1'b0;
                    n_last = 1'b1;
                    o_pop  = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
        r_tok  <= n_tok;
        r_last <= n_last;
    end

    assign o_tok_valid    = r_valid;
    assign o_token_kind   = r_tok.kind;
    assign o_token_start  = r_tok.start;
    assign o_token_length = r_tok.length;
    assign o_last_of_item = r_last;

    `BST_ASSERT_IMPL(a_end_is_last, i_clk, i_rst_n, r_valid && (r_tok.kind == bst_pkg::K_END), r_last)
    `BST_ASSERT_IMPL(a_sel_has_pair, i_clk, i_rst_n, r_sel, i_head.valid && i_head.entry.two && r_valid)

endmodule
`default_nettype wire
